// ===== design/mvcrw_pkg.sv =====
package mvcrw_pkg;

   // Payload widths fixed by the sample format
   localparam int MIX_W      = 24;
   localparam int TIME_W     = 16;
   localparam int ADDR_W     = 16;
   localparam int WORD_W     = 16;
   localparam int VOLUME_W   = 9;
   localparam int LOG2_W     = 5;
   localparam int PROD_W     = MIX_W + VOLUME_W + 1;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MASTER_VOLUME = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_FORMAT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEREO_MODE   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_LOG2     = 4'd3;

   // Output format codes
   localparam logic FORMAT_S16 = 1'b0;
   localparam logic FORMAT_U8  = 1'b1;

   // Reset values and sample constants
   localparam logic [VOLUME_W-1:0] VOLUME_UNITY    = 9'd256;
   localparam logic [LOG2_W-1:0]   RING_LOG2_RESET = 5'd14;
   localparam logic [WORD_W-1:0]   SAT_MAX         = 16'h7fff;
   localparam logic [WORD_W-1:0]   SAT_MIN         = 16'h8000;
   localparam logic [7:0]          BYTE_BIAS       = 8'd128;

   typedef struct packed {
      logic [VOLUME_W-1:0] master_volume;
      logic                output_format;
      logic                stereo_mode;
      logic [LOG2_W-1:0]   ring_log2;
   } cfg_type;

   // One channel sample on its way through the gain pipeline
   typedef struct packed {
      logic [ADDR_W-1:0]       write_address;
      logic                    last_of_frame;
      logic signed [MIX_W-1:0] mix;
   } lane_type;

endpackage

// ===== design/mvcrw_if.sv =====
interface mvcrw_req_if import mvcrw_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [MIX_W-1:0] mix_left;
   logic signed [MIX_W-1:0] mix_right;
   logic [TIME_W-1:0]       frame_time;

   modport source (output valid, output mix_left, output mix_right, output frame_time,
                   input ready);
   modport sink   (input valid, input mix_left, input mix_right, input frame_time,
                   output ready);
endinterface

interface mvcrw_rsp_if import mvcrw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [WORD_W-1:0] sample_word;
   logic              last_of_frame;

   modport source (output valid, output write_address, output sample_word,
                   output last_of_frame, input ready);
   modport sink   (input valid, input write_address, input sample_word,
                   input last_of_frame, output ready);
endinterface

interface mvcrw_csr_if import mvcrw_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== design/mvcrw_splitter.sv =====
module mvcrw_splitter import mvcrw_pkg::*; #(
   parameter int RING_LOG2_MAX = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   mvcrw_req_if.sink req,
   output lane_type lane_out,
   output logic     lane_valid,
   input  logic     lane_ready
);

   localparam int CALC_W = (RING_LOG2_MAX > TIME_W + 1) ? RING_LOG2_MAX : TIME_W + 1;

   logic                    hold_valid_ff, hold_valid_in;
   logic                    lane_sel_ff, lane_sel_in;
   logic signed [MIX_W-1:0] mix_left_ff, mix_right_ff;
   logic [TIME_W-1:0]       frame_time_ff;

   logic              accept, take, last;
   logic [LOG2_W-1:0] lg_eff;
   logic [CALC_W-1:0] ring_mask, position, masked;

   assign last       = !cfg.stereo_mode || lane_sel_ff;
   assign lane_valid = hold_valid_ff;
   assign take       = lane_valid && lane_ready;
   assign req.ready  = !hold_valid_ff || (take && last);
   assign accept     = req.valid && req.ready;

   // Clamp the ring size, then build the address mask bit by bit
   assign lg_eff = (cfg.ring_log2 > LOG2_W'(RING_LOG2_MAX)) ? LOG2_W'(RING_LOG2_MAX)
                                                            : cfg.ring_log2;
   always_comb begin
      for (int i = 0; i < CALC_W; i++) begin
         ring_mask[i] = (LOG2_W'(i) < lg_eff);
      end
   end

   assign position = cfg.stereo_mode ? CALC_W'({frame_time_ff, lane_sel_ff})
                                     : CALC_W'(frame_time_ff);
   assign masked   = position & ring_mask;

   always_comb begin
      lane_out.write_address = masked[ADDR_W-1:0];
      lane_out.last_of_frame = last;
      lane_out.mix           = lane_sel_ff ? mix_right_ff : mix_left_ff;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      lane_sel_in   = lane_sel_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         lane_sel_in   = 1'b0;
      end else if (take && last) begin
         hold_valid_in = 1'b0;
      end else if (take) begin
         lane_sel_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         lane_sel_ff   <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         lane_sel_ff   <= lane_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mix_left_ff   <= req.mix_left;
         mix_right_ff  <= req.mix_right;
         frame_time_ff <= req.frame_time;
      end
   end

   a_left_then_right: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (hold_valid_ff && lane_sel_ff))
      else $error("left lane sent without right lane following");

   a_mono_single: assert property (@(posedge clock) disable iff (reset)
      (lane_valid && !cfg.stereo_mode) |-> lane_out.last_of_frame)
      else $error("mono lane not marked last");

   a_load_left: assert property (@(posedge clock) disable iff (reset)
      accept |=> (hold_valid_ff && !lane_sel_ff))
      else $error("new request does not start on the left lane");

endmodule

// ===== design/mvcrw_lane_pipe.sv =====
module mvcrw_lane_pipe import mvcrw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  lane_type lane_in,
   input  logic     lane_valid,
   output logic     lane_ready,
   mvcrw_rsp_if.source rsp
);

   localparam int SHIFT_W = PROD_W - 8;

   // Stage 1: product
   logic                     s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]        s1_addr_ff;
   logic                     s1_last_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   // Stage 2: saturated sample
   logic                     s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0]        s2_addr_ff;
   logic                     s2_last_ff;
   logic [WORD_W-1:0]        sat_ff, sat_in;
   // Stage 3: output word
   logic                     s3_valid_ff, s3_valid_in;
   logic [ADDR_W-1:0]        s3_addr_ff;
   logic                     s3_last_ff;
   logic [WORD_W-1:0]        word_ff, word_in;

   logic                      adv1, adv2, adv3;
   logic signed [SHIFT_W-1:0] shifted;

   assign adv3       = !s3_valid_ff || rsp.ready;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign lane_ready = adv1;

   assign prod_in = lane_in.mix * $signed({1'b0, cfg.master_volume});

   // Arithmetic shift right by 8 is a floor divide by 256
   assign shifted = prod_ff[PROD_W-1:8];
   always_comb begin
      if (shifted > $signed(SHIFT_W'(SAT_MAX))) begin
         sat_in = SAT_MAX;
      end else if (shifted < SHIFT_W'($signed(SAT_MIN))) begin
         sat_in = SAT_MIN;
      end else begin
         sat_in = shifted[WORD_W-1:0];
      end
   end

   // Flipping the top bit adds the 128 bias to the signed high byte
   assign word_in = (cfg.output_format == FORMAT_U8) ? {8'h00, sat_ff[15:8] ^ BYTE_BIAS}
                                                     : sat_ff;

   always_comb begin
      s1_valid_in = adv1 ? lane_valid  : s1_valid_ff;
      s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff    <= prod_in;
         s1_addr_ff <= lane_in.write_address;
         s1_last_ff <= lane_in.last_of_frame;
      end
      if (adv2) begin
         sat_ff     <= sat_in;
         s2_addr_ff <= s1_addr_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (adv3) begin
         word_ff    <= word_in;
         s3_addr_ff <= s2_addr_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   assign rsp.valid         = s3_valid_ff;
   assign rsp.write_address = s3_addr_ff;
   assign rsp.sample_word   = word_ff;
   assign rsp.last_of_frame = s3_last_ff;

   a_byte_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && cfg.output_format == FORMAT_U8) |-> (rsp.sample_word[15:8] == 8'h00))
      else $error("8-bit sample with upper byte set");

   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv2) |=> (sat_ff[WORD_W-1] == $past(prod_ff[PROD_W-1])))
      else $error("saturation changed the sample sign");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv2) |=> (s1_valid_ff && $stable(prod_ff) && $stable(s1_addr_ff)))
      else $error("stalled product stage lost or changed its sample");

endmodule

// ===== design/mix_volume_clip_ring_writer_core.sv =====
// Channel   Dir  Modport  Payload
// req_chan  in   sink     mix_left[23:0] s, mix_right[23:0] s, frame_time[15:0]
// rsp_chan  out  source   write_address[15:0], sample_word[15:0], last_of_frame
// csr_chan  in   sink     reg_index[3:0], write_data[15:0]; always ready
//
// The splitter feeds the single multiply/saturate/format pipeline one channel
// sample per cycle while lane_ready is high: two per stereo request, one mono.
// Results pass the product, saturation and output stages to reach rsp_chan.
// Reset (synchronous, active high) empties every stage and loads the register
// reset values: unity volume, 16-bit format, stereo, ring of 2^14 samples.
// A stall on rsp_chan holds each full stage in place and backs up to req_chan.
module mix_volume_clip_ring_writer_core import mvcrw_pkg::*; #(
   parameter int RING_LOG2_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   mvcrw_req_if.sink   req_chan,
   mvcrw_rsp_if.source rsp_chan,
   mvcrw_csr_if.sink   csr_chan
);

   cfg_type  cfg_ff, cfg_in;
   lane_type lane;
   logic     lane_valid, lane_ready;
   logic     csr_write;

   // Register writes are always taken; unknown indexes drop
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_chan.reg_index)
            REG_MASTER_VOLUME: cfg_in.master_volume = csr_chan.write_data[VOLUME_W-1:0];
            REG_OUTPUT_FORMAT: cfg_in.output_format = csr_chan.write_data[0];
            REG_STEREO_MODE:   cfg_in.stereo_mode   = csr_chan.write_data[0];
            REG_RING_LOG2:     cfg_in.ring_log2     = csr_chan.write_data[LOG2_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_volume <= VOLUME_UNITY;
         cfg_ff.output_format <= FORMAT_S16;
         cfg_ff.stereo_mode   <= 1'b1;
         cfg_ff.ring_log2     <= RING_LOG2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold the request; send one channel per ready cycle, with ring addresses
   mvcrw_splitter #(
      .RING_LOG2_MAX (RING_LOG2_MAX)
   ) u_splitter (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .lane_out   (lane),
      .lane_valid (lane_valid),
      .lane_ready (lane_ready)
   );

   // Gain, floor shift, clip to 16 bits, then pick the output format
   mvcrw_lane_pipe u_lane_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .lane_in    (lane),
      .lane_valid (lane_valid),
      .lane_ready (lane_ready),
      .rsp        (rsp_chan)
   );

endmodule
